// File: rtl/core/dwp_pkg.sv
// Shared types, codes and constants for the widget packet parser.
// No dependencies; every other file in rtl/core imports this package.
package dwp_pkg;

  // Default values for the top-level parameters.
  localparam int BUFFER_DEPTH_DEF = 513;
  localparam int MIN_FRAME_DEF    = 25;
  localparam int MAX_USER_LEN_DEF = 48;

  // Field widths.
  localparam int SLOT_W     = 10;  // slot index and slot count
  localparam int STEP_W     = 6;   // result counter, longest reply is 58 bytes plus status
  localparam int UL_W       = 6;   // saturated user length, at most 48
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register map, indexed by paddr[2].
  localparam logic REG_SERIAL_NUMBER = 1'b0;
  localparam logic [CFG_DATA_W-1:0] SERIAL_RESET = 32'hFFFF_FFFF;

  // Frame delimiters and labels.
  localparam logic [7:0] START_DELIM  = 8'h7E;
  localparam logic [7:0] END_DELIM    = 8'hE7;
  localparam logic [7:0] LBL_INFO     = 8'd3;
  localparam logic [7:0] LBL_SEND_DMX = 8'd6;
  localparam logic [7:0] LBL_SERIAL   = 8'd10;

  // Fixed contents of the info reply.
  localparam logic [7:0] INFO_FW_LO   = 8'd44;
  localparam logic [7:0] INFO_FW_HI   = 8'd1;
  localparam logic [7:0] INFO_BREAK   = 8'd9;
  localparam logic [7:0] INFO_MAB     = 8'd1;
  localparam logic [7:0] INFO_RATE    = 8'd0;
  localparam logic [7:0] INFO_HDR_LEN = 8'd5;
  localparam logic [7:0] SERIAL_LEN   = 8'd4;

  typedef enum logic [1:0] {
    RES_STATUS = 2'd0,
    RES_REPLY  = 2'd1,
    RES_SLOT   = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    PKT_DROPPED = 2'd0,
    PKT_GOOD    = 2'd1,
    PKT_BAD_END = 2'd2
  } pkt_status_t;

  typedef enum logic [1:0] {
    REPLY_NONE   = 2'd0,
    REPLY_INFO   = 2'd1,
    REPLY_SERIAL = 2'd2
  } reply_t;

  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_LABEL   = 6'b000010,
    PH_LEN_LO  = 6'b000100,
    PH_LEN_HI  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_END     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic              action;
    logic [7:0]        rx_byte;
    logic [SLOT_W-1:0] slot_index;
  } item_t;

  // What the parser wants emitted for the item in the input register:
  // an optional reply frame followed by one final result.
  typedef struct packed {
    logic              emit;
    reply_t            reply;
    logic [UL_W-1:0]   user_len;
    result_kind_t      kind;
    pkt_status_t       status;
    logic [7:0]        label;
    logic [SLOT_W-1:0] count;
    logic [7:0]        data;
  } desc_t;

  // Byte number step of a reply frame.
  function automatic logic [7:0] reply_byte(reply_t r, logic [STEP_W-1:0] step,
                                            logic [UL_W-1:0] ul,
                                            logic [CFG_DATA_W-1:0] sn);
    logic [7:0] b;
    b = 8'd0;
    case (r)
      REPLY_INFO: begin
        case (step)
          6'd0:    b = START_DELIM;
          6'd1:    b = LBL_INFO;
          6'd2:    b = 8'(ul) + INFO_HDR_LEN;
          6'd3:    b = 8'd0;
          6'd4:    b = INFO_FW_LO;
          6'd5:    b = INFO_FW_HI;
          6'd6:    b = INFO_BREAK;
          6'd7:    b = INFO_MAB;
          6'd8:    b = INFO_RATE;
          default: b = (step == STEP_W'(ul) + 6'd9) ? END_DELIM : 8'd0;
        endcase
      end
      REPLY_SERIAL: begin
        case (step)
          6'd0:    b = START_DELIM;
          6'd1:    b = LBL_SERIAL;
          6'd2:    b = SERIAL_LEN;
          6'd3:    b = 8'd0;
          6'd4:    b = sn[7:0];
          6'd5:    b = sn[15:8];
          6'd6:    b = sn[23:16];
          6'd7:    b = sn[31:24];
          6'd8:    b = END_DELIM;
          default: b = 8'd0;
        endcase
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/dwp_ifs.sv
// Valid/ready channel interfaces for the widget packet parser.
// Depends on dwp_pkg for field widths.
interface dwp_in_if
  import dwp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [7:0]        rx_byte;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, action, rx_byte, slot_index, input ready);
  modport sink   (input valid, action, rx_byte, slot_index, output ready);
endinterface

interface dwp_out_if
  import dwp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [1:0]        packet_status;
  logic [7:0]        packet_label;
  logic [SLOT_W-1:0] slot_count;
  logic [7:0]        data_byte;
  logic              last;

  modport source (output valid, result_kind, packet_status, packet_label, slot_count,
                  data_byte, last, input ready);
  modport sink   (input valid, result_kind, packet_status, packet_label, slot_count,
                  data_byte, last, output ready);
endinterface

// File: rtl/core/dwp_apb_regs.sv
// APB-style configuration register block: holds the serial number.
// Depends on dwp_pkg.
module dwp_apb_regs
  import dwp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CFG_DATA_W-1:0] serial_number
);

  logic sel_serial;

  assign pready     = 1'b1;
  assign sel_serial = (paddr[2] == REG_SERIAL_NUMBER);

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_number <= SERIAL_RESET;
    end else if (psel && penable && pwrite && sel_serial) begin
      serial_number <= pwdata;
    end
  end

  always_comb begin
    prdata = sel_serial ? serial_number : '0;
  end

endmodule

// File: rtl/core/dwp_slot_mem.sv
// Slot buffer memory with a fill count that stands in for the zero reset,
// and a registered read that forwards a write to the same slot.
// Depends on dwp_pkg.
module dwp_slot_mem
  import dwp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                      wr_data,
  input  logic                            rd_en,
  input  logic [SLOT_W-1:0]               rd_addr,
  output logic [7:0]                      rd_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int FW = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [FW-1:0] fill;
  logic          rd_hit;
  logic          rd_filled;

  // Payload always lands at consecutive slots from zero, so every slot
  // below the fill count has been written since reset.
  assign rd_hit    = wr_en && (rd_addr == SLOT_W'(wr_addr));
  assign rd_filled = (rd_addr < SLOT_W'(fill));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && (FW'(wr_addr) == fill)) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (rd_hit) begin
        rd_data <= wr_data;
      end else if (rd_filled) begin
        rd_data <= mem[rd_addr[AW-1:0]];
      end else begin
        rd_data <= 8'd0;
      end
    end
  end

endmodule

// File: rtl/core/dwp_frame_parser.sv
// Frame parser: phase machine and frame state, decides the results for
// the registered item and updates its state when that item is consumed.
// Depends on dwp_pkg.
module dwp_frame_parser
  import dwp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int MIN_FRAME    = MIN_FRAME_DEF,
  parameter int MAX_USER_LEN = MAX_USER_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  item_t                           item,
  input  logic                            consume,
  input  logic [7:0]                      slot_data,
  output desc_t                           desc,
  output logic                            wr_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [7:0]                      wr_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  phase_t            phase;
  phase_t            phase_next;
  logic [7:0]        frame_label;
  logic [15:0]       frame_length;
  logic [15:0]       payload_count;
  logic [15:0]       user_info_length;
  logic [SLOT_W-1:0] valid_slots;
  logic [SLOT_W-1:0] valid_slots_next;
  logic [16:0]       len_min;
  logic [16:0]       len_clamped;
  logic [16:0]       count_inc;
  logic [15:0]       full_length;
  logic              step_byte;
  logic              good_end;

  assign step_byte   = consume && !item.action;
  assign good_end    = (item.rx_byte == END_DELIM);
  assign count_inc   = {1'b0, payload_count} + 17'd1;
  assign full_length = {item.rx_byte, frame_length[7:0]};

  // Length clamped to MIN_FRAME..BUFFER_DEPTH, in that order.
  always_comb begin
    len_min     = ({1'b0, frame_length} < 17'(MIN_FRAME)) ? 17'(MIN_FRAME)
                                                          : {1'b0, frame_length};
    len_clamped = (len_min > 17'(BUFFER_DEPTH)) ? 17'(BUFFER_DEPTH) : len_min;
  end

  assign wr_en   = step_byte && (phase == PH_PAYLOAD) && (frame_label == LBL_SEND_DMX)
                   && (payload_count < 16'(BUFFER_DEPTH));
  assign wr_addr = payload_count[AW-1:0];
  assign wr_data = item.rx_byte;

  always_comb begin
    desc             = '0;
    desc.reply       = REPLY_NONE;
    desc.kind        = RES_STATUS;
    desc.status      = PKT_DROPPED;
    desc.user_len    = (user_info_length > 16'(MAX_USER_LEN)) ? UL_W'(MAX_USER_LEN)
                                                              : UL_W'(user_info_length);
    valid_slots_next = valid_slots;
    if (item.action) begin
      desc.emit  = 1'b1;
      desc.kind  = RES_SLOT;
      desc.count = valid_slots;
      desc.data  = slot_data;
    end else if (phase == PH_START) begin
      if (item.rx_byte != START_DELIM) begin
        desc.emit  = 1'b1;
        desc.count = valid_slots;
      end
    end else if (phase == PH_END) begin
      desc.emit  = 1'b1;
      desc.label = frame_label;
      if (good_end) begin
        desc.status = PKT_GOOD;
        if (frame_label == LBL_SEND_DMX) begin
          valid_slots_next = SLOT_W'(len_clamped - 17'd1);
        end else if (frame_label == LBL_INFO) begin
          desc.reply = REPLY_INFO;
        end else if (frame_label == LBL_SERIAL) begin
          desc.reply = REPLY_SERIAL;
        end
      end else begin
        desc.status = PKT_BAD_END;
        if (frame_label == LBL_SEND_DMX) begin
          valid_slots_next = '0;
        end
      end
      desc.count = valid_slots_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_START:   phase_next = (item.rx_byte == START_DELIM) ? PH_LABEL : PH_START;
      PH_LABEL:   phase_next = PH_LEN_LO;
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI:  phase_next = (full_length == 16'd0) ? PH_END : PH_PAYLOAD;
      PH_PAYLOAD: phase_next = (count_inc >= {1'b0, frame_length}) ? PH_END : PH_PAYLOAD;
      PH_END:     phase_next = PH_START;
      default:    phase_next = PH_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      frame_label      <= '0;
      frame_length     <= '0;
      payload_count    <= '0;
      user_info_length <= '0;
      valid_slots      <= '0;
    end else if (step_byte) begin
      phase <= phase_next;
      case (phase)
        PH_LABEL: begin
          frame_label      <= item.rx_byte;
          user_info_length <= '0;
          payload_count    <= '0;
        end
        PH_LEN_LO: frame_length <= {8'd0, item.rx_byte};
        PH_LEN_HI: frame_length <= full_length;
        PH_PAYLOAD: begin
          if ((frame_label == LBL_INFO) && (frame_length == 16'd2)) begin
            if (payload_count == 16'd0) begin
              user_info_length <= {8'd0, item.rx_byte};
            end else begin
              user_info_length <= {item.rx_byte, user_info_length[7:0]};
            end
          end
          payload_count <= count_inc[15:0];
        end
        PH_END:  valid_slots <= valid_slots_next;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/dwp_result_seq.sv
// Result sequencer: walks the reply bytes and the final result of the
// registered item into the output register, one result per cycle unless stalled.
// Depends on dwp_pkg and dwp_out_if.
module dwp_result_seq
  import dwp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  desc_t                 desc,
  input  logic [CFG_DATA_W-1:0] serial_number,
  output logic                  consume,
  dwp_out_if.source             rsp
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic              out_valid;
  logic              out_free;
  logic              load;
  logic              at_last;

  always_comb begin
    case (desc.reply)
      REPLY_INFO:   last_step = STEP_W'(desc.user_len) + 6'd10;
      REPLY_SERIAL: last_step = 6'd9;
      default:      last_step = '0;
    endcase
  end

  assign out_free = !out_valid || rsp.ready;
  assign at_last  = (step == last_step);
  assign load     = item_valid && desc.emit && out_free;
  assign consume  = item_valid && (!desc.emit || (out_free && at_last));
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= at_last ? '0 : step + 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.last <= at_last;
      if (at_last) begin
        rsp.result_kind   <= desc.kind;
        rsp.packet_status <= desc.status;
        rsp.packet_label  <= desc.label;
        rsp.slot_count    <= desc.count;
        rsp.data_byte     <= desc.data;
      end else begin
        rsp.result_kind   <= RES_REPLY;
        rsp.packet_status <= PKT_DROPPED;
        rsp.packet_label  <= 8'd0;
        rsp.slot_count    <= '0;
        rsp.data_byte     <= reply_byte(desc.reply, step, desc.user_len, serial_number);
      end
    end
  end

endmodule

// File: rtl/core/dmx_widget_packet_parser.sv
// Widget packet parser top level: serial frame parsing, slot buffer and
// reply generation. Depends on dwp_pkg, dwp_ifs and every dwp_* module but dwp_checker.
//
// Usage. Items arrive on the req channel (valid/ready); action 0 carries a
// serial byte in rx_byte, action 1 asks for buffered slot slot_index.
// Results leave on the rsp channel, one transaction per result, with last
// set on the final result belonging to an item. Bytes inside a frame and the
// start byte give no result. A Get-Info frame answers with a reply frame of
// 10 to 58 bytes ahead of its status; a Get-Serial frame with 9 bytes.
// The serial number is set through the APB port, register 0 at address 0.
//
// Timing. An accepted item sits in the input register; its first result is
// then loaded into the output register. Items with at most one result are
// taken back to back, one per cycle while the output is not stalled. An
// item with more results holds the input register while the sequencer
// steps through them, so ready stays low until its last result is loaded.
//
// Reset clears the phase machine, frame state, slot count and the fill count
// of the slot buffer, so unwritten slots read as zero without a clearing
// pass. When the receiver stalls, the output holds its transaction; the input
// register takes items until one with a result waits there, then ready drops.
module dmx_widget_packet_parser
  import dwp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int MIN_FRAME    = MIN_FRAME_DEF,
  parameter int MAX_USER_LEN = MAX_USER_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dwp_in_if.sink                req,
  dwp_out_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  item_t                 item;
  logic                  item_valid;
  logic                  consume;
  logic                  accept;
  desc_t                 desc;
  logic [CFG_DATA_W-1:0] serial_number;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [7:0]            wr_data;
  logic [7:0]            slot_data;

  // The input register frees up in the same cycle its item is consumed,
  // so a new transaction can follow every cycle while items are consumed.
  assign req.ready = !item_valid || consume;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.action     <= req.action;
      item.rx_byte    <= req.rx_byte;
      item.slot_index <= req.slot_index;
    end
  end

  dwp_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .serial_number (serial_number)
  );

  // The slot read is launched as the item is accepted, so its data is
  // ready alongside the item in the input register.
  dwp_slot_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (req.slot_index),
    .rd_data (slot_data)
  );

  dwp_frame_parser #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MIN_FRAME    (MIN_FRAME),
    .MAX_USER_LEN (MAX_USER_LEN)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .consume   (consume),
    .slot_data (slot_data),
    .desc      (desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  dwp_result_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .desc          (desc),
    .serial_number (serial_number),
    .consume       (consume),
    .rsp           (rsp)
  );

endmodule

// File: rtl/core/dwp_checker.sv
// Port-level checks for the widget packet parser, bound to the top level.
// Depends on dwp_pkg.
module dwp_checker
  import dwp_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        rsp_kind,
  input logic [1:0]        rsp_status,
  input logic [7:0]        rsp_label,
  input logic [SLOT_W-1:0] rsp_count,
  input logic [7:0]        rsp_data,
  input logic              rsp_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid
      && $stable({rsp_kind, rsp_status, rsp_label, rsp_count, rsp_data, rsp_last}))
    else $error("result changed while stalled");

  a_reply_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == RES_REPLY) |-> !rsp_last && (rsp_status == PKT_DROPPED)
      && (rsp_label == 8'd0) && (rsp_count == '0))
    else $error("reply byte result carries status fields or last");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_count <= SLOT_W'(BUFFER_DEPTH - 1)))
    else $error("slot count beyond buffer depth");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind dmx_widget_packet_parser dwp_checker #(
  .BUFFER_DEPTH (BUFFER_DEPTH)
) u_dwp_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_kind   (rsp.result_kind),
  .rsp_status (rsp.packet_status),
  .rsp_label  (rsp.packet_label),
  .rsp_count  (rsp.slot_count),
  .rsp_data   (rsp.data_byte),
  .rsp_last   (rsp.last)
);
